// File: design/bounded_priority_queue_unit_assert.svh
// Assertion helpers shared by the queue RTL.
`ifndef BOUNDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bpq_pkg.sv
package bpq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TDATA_W = 40;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_SORT = 2'd1,
    CMD_DEQ  = 2'd2,
    CMD_MAX  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Broadcast to every cell; positions travel beside it.
  typedef struct packed {
    logic                      shift_up;  // cell at pos_a+1 takes its lower neighbor
    logic                      wr_lo;     // cell at pos_a takes operand
    logic                      wr_hi;     // cell at pos_a+1 takes operand
    logic                      shift_dn;  // cells in [pos_a, pos_b) take upper neighbor
    logic signed [VALUE_W-1:0] operand;
  } cell_ctl_t;

endpackage

// File: design/bpq_cell.sv
module bpq_cell #(
  parameter int unsigned AW    = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic                               clk_i,
  input  bpq_pkg::cell_ctl_t                 ctl_i,
  input  logic [AW-1:0]                      pos_a_i,
  input  logic [AW-1:0]                      pos_b_i,
  input  logic signed [bpq_pkg::VALUE_W-1:0] prev_data_i,
  input  logic signed [bpq_pkg::VALUE_W-1:0] next_data_i,
  output logic signed [bpq_pkg::VALUE_W-1:0] data_o,
  output logic                               lt_o,
  output logic                               gt_o
);

  localparam int unsigned IW = AW + 1;
  localparam logic [IW-1:0] IDX = IW'(INDEX);

  logic signed [bpq_pkg::VALUE_W-1:0] data_q, data_d;
  logic [IW-1:0] pos_a_x, pos_a1_x, pos_b_x;
  logic at_a, at_a1, in_rng;

  assign pos_a_x  = {1'b0, pos_a_i};
  assign pos_a1_x = pos_a_x + IW'(1);
  assign pos_b_x  = {1'b0, pos_b_i};
  assign at_a     = (pos_a_x == IDX);
  assign at_a1    = (pos_a1_x == IDX);
  assign in_rng   = (IDX >= pos_a_x) && (IDX < pos_b_x);

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_dn && in_rng) begin
      data_d = next_data_i;
    end
    if (ctl_i.shift_up && at_a1) begin
      data_d = prev_data_i;
    end
    if (ctl_i.wr_hi && at_a1) begin
      data_d = ctl_i.operand;
    end
    if (ctl_i.wr_lo && at_a) begin
      data_d = ctl_i.operand;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign lt_o   = (data_q < ctl_i.operand);
  assign gt_o   = (data_q > ctl_i.operand);

endmodule

// File: design/bounded_priority_queue_unit.sv
// Bounded priority queue of DEPTH signed 32-bit entries held in a row of cells.
// Input stream s_axis: one beat is one command (enqueue, sorted enqueue,
// dequeue head, remove largest) with a value for inserts. Output stream
// m_axis: exactly one beat per command, the removed value and a status.
// Enqueue, dequeue and removal of the last entry register their result in
// the cycle of acceptance. Sorted enqueue walks one cell per cycle from the
// tail down until the value lands, at the latest at the head. Remove largest
// scans one cell per cycle from the head, then shifts the cells above the
// largest entry down together in ST_SHIFT.
// A new command is taken once the previous one has finished.
// Results go to an output register backed by one skid register, so a
// command is accepted while one result still waits; with both full,
// s_axis_tready drops until the receiver takes a beat.
// Reset (rst_ni low, asynchronous) empties the queue and drops pending
// output beats; cell contents are not cleared and are never read unwritten.
`include "bounded_priority_queue_unit_assert.svh"

module bounded_priority_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bpq_pkg::TDATA_W-1:0] s_axis_tdata,  // [1:0] cmd, [33:2] value_in
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bpq_pkg::TDATA_W-1:0] m_axis_tdata   // [31:0] value_out, [33:32] status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned VW = bpq_pkg::VALUE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         head_q, head_d, tail_q, tail_d, cur_q, cur_d, idx_q, idx_d;
  logic                  empty_q, empty_d;
  logic signed [VW-1:0]  val_q, val_d;
  logic                  out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic signed [VW-1:0]  out_val_q, out_val_d, skid_val_q, skid_val_d;
  bpq_pkg::status_e      out_st_q, out_st_d, skid_st_q, skid_st_d;

  bpq_pkg::cell_ctl_t    ctl;
  logic [AW-1:0]         pos_a, pos_b, rd_sel;
  logic signed [VW-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_lt, cell_gt;
  logic signed [VW-1:0]  rd_data;
  logic                  lt_cur, gt_cur;

  logic                  in_beat, full;
  bpq_pkg::cmd_e         in_cmd;
  logic signed [VW-1:0]  in_val;
  logic                  res_v;
  logic signed [VW-1:0]  res_val;
  bpq_pkg::status_e      res_st;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [VW-1:0] prev_data, next_data;
    if (k == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_prev
      assign prev_data = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_next
      assign next_data = cell_data[k+1];
    end
    bpq_cell #(
      .AW    (AW),
      .INDEX (k)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .pos_a_i     (pos_a),
      .pos_b_i     (pos_b),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[k]),
      .lt_o        (cell_lt[k]),
      .gt_o        (cell_gt[k])
    );
  end

  // One-hot read of the cell under the head or the cursor
  assign rd_sel = (state_q == ST_IDLE) ? head_q : cur_q;

  always_comb begin
    rd_data = '0;
    lt_cur  = 1'b0;
    gt_cur  = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      if (AW'(k) == rd_sel) begin
        rd_data = rd_data | cell_data[k];
        lt_cur  = lt_cur | cell_lt[k];
        gt_cur  = gt_cur | cell_gt[k];
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !skid_v_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = bpq_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign in_val        = s_axis_tdata[VW+1:2];
  assign full          = !empty_q && (tail_q == AW'(DEPTH - 1));

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    empty_d    = empty_q;
    val_d      = val_q;
    ctl        = '0;
    pos_a      = '0;
    pos_b      = '0;
    res_v      = 1'b0;
    res_val    = '0;
    res_st     = bpq_pkg::STAT_DONE;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          case (in_cmd)
            bpq_pkg::CMD_ENQ, bpq_pkg::CMD_SORT: begin
              ctl.operand = in_val;
              if (full) begin
                res_v  = 1'b1;
                res_st = bpq_pkg::STAT_FULL;
              end else if (empty_q) begin
                ctl.wr_lo = 1'b1;
                head_d    = '0;
                tail_d    = '0;
                empty_d   = 1'b0;
                res_v     = 1'b1;
              end else if (in_cmd == bpq_pkg::CMD_ENQ) begin
                ctl.wr_lo = 1'b1;
                pos_a     = tail_q + AW'(1);
                tail_d    = tail_q + AW'(1);
                res_v     = 1'b1;
              end else begin
                val_d   = in_val;
                cur_d   = tail_q;
                state_d = ST_INS;
              end
            end
            bpq_pkg::CMD_DEQ, bpq_pkg::CMD_MAX: begin
              if (empty_q) begin
                res_v  = 1'b1;
                res_st = bpq_pkg::STAT_EMPTY;
              end else if (head_q == tail_q) begin
                res_v   = 1'b1;
                res_val = rd_data;
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b1;
              end else if (in_cmd == bpq_pkg::CMD_DEQ) begin
                res_v   = 1'b1;
                res_val = rd_data;
                head_d  = head_q + AW'(1);
              end else begin
                val_d   = rd_data;
                idx_d   = head_q;
                cur_d   = head_q + AW'(1);
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Walk down from the tail; each smaller entry moves up one cell
      ST_INS: begin
        ctl.operand = val_q;
        pos_a       = cur_q;
        if (lt_cur) begin
          ctl.shift_up = 1'b1;
          if (cur_q == head_q) begin
            ctl.wr_lo = 1'b1;
            tail_d    = tail_q + AW'(1);
            res_v     = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            cur_d = cur_q - AW'(1);
          end
        end else begin
          ctl.wr_hi = 1'b1;
          tail_d    = tail_q + AW'(1);
          res_v     = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      // Strictly greater keeps the first maximum from the head
      ST_SCAN: begin
        ctl.operand = val_q;
        if (gt_cur) begin
          val_d = rd_data;
          idx_d = cur_q;
        end
        if (cur_q == tail_q) begin
          state_d = ST_SHIFT;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end

      ST_SHIFT: begin
        ctl.shift_dn = 1'b1;
        pos_a        = idx_q;
        pos_b        = tail_q;
        tail_d       = tail_q - AW'(1);
        res_v        = 1'b1;
        res_val      = val_q;
        state_d      = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register with one skid entry behind it
  always_comb begin
    out_v_d    = out_v_q;
    out_val_d  = out_val_q;
    out_st_d   = out_st_q;
    skid_v_d   = skid_v_q;
    skid_val_d = skid_val_q;
    skid_st_d  = skid_st_q;
    if (out_v_q && m_axis_tready) begin
      out_v_d = 1'b0;
      if (skid_v_q) begin
        out_v_d   = 1'b1;
        out_val_d = skid_val_q;
        out_st_d  = skid_st_q;
        skid_v_d  = 1'b0;
      end
    end
    if (res_v) begin
      if (!out_v_d) begin
        out_v_d   = 1'b1;
        out_val_d = res_val;
        out_st_d  = res_st;
      end else begin
        skid_v_d   = 1'b1;
        skid_val_d = res_val;
        skid_st_d  = res_st;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      cur_q      <= '0;
      idx_q      <= '0;
      empty_q    <= 1'b1;
      val_q      <= '0;
      out_v_q    <= 1'b0;
      out_val_q  <= '0;
      out_st_q   <= bpq_pkg::STAT_DONE;
      skid_v_q   <= 1'b0;
      skid_val_q <= '0;
      skid_st_q  <= bpq_pkg::STAT_DONE;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cur_q      <= cur_d;
      idx_q      <= idx_d;
      empty_q    <= empty_d;
      val_q      <= val_d;
      out_v_q    <= out_v_d;
      out_val_q  <= out_val_d;
      out_st_q   <= out_st_d;
      skid_v_q   <= skid_v_d;
      skid_val_q <= skid_val_d;
      skid_st_q  <= skid_st_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(bpq_pkg::TDATA_W - VW - 2){1'b0}}, out_st_q, out_val_q};

  `BPQ_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid entry without output entry")
  `BPQ_ASSERT_NOW(a_empty_at_zero, empty_q, (head_q == '0) && (tail_q == '0),
                  "empty queue with moved positions")
  `BPQ_ASSERT_NOW(a_head_le_tail, !empty_q, head_q <= tail_q, "head past tail")
  `BPQ_ASSERT_NEXT(a_shift_answers, state_q == ST_SHIFT, (state_q == ST_IDLE) && out_v_q,
                   "remove-largest finished without a result")

endmodule
